// File: design/bph_pkg.sv
// Shared types and constants for the byte pair histogram.
// Used by the front end, back end and top level; depends on nothing.
package bph_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int SYMBOLS_DEF = 256;
	localparam int BYTE_COUNTER_WIDTH_DEF = 40;

	localparam int GAIN_W = 16;
	localparam int PIXEL_W = 32;
	localparam int SEEN_W = 40;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd1000;
	localparam logic [PIXEL_W-1:0] ALPHA_FULL = 32'hFF00_0000;

	localparam logic [1:0] CMD_FEED = 2'd0;
	localparam logic [1:0] CMD_READ = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	typedef enum logic [2:0] {
		KIND_FIRST,
		KIND_FEED,
		KIND_READ,
		KIND_CLEAR,
		KIND_BAD
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [SEEN_W-1:0] seen;
	} job_t;

endpackage

// File: design/bph_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.
module bph_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/bph_front.sv
// Front end: accepts stream items, tracks previous byte and byte counter,
// classifies each item into a job for the back end. Depends on bph_pkg.
module bph_front #(
	parameter int SYMBOLS = bph_pkg::SYMBOLS_DEF,
	parameter int BYTE_COUNTER_WIDTH = bph_pkg::BYTE_COUNTER_WIDTH_DEF,
	localparam int ADDR_W = $clog2(SYMBOLS * SYMBOLS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [23:0]         s_tdata,
	input  logic [1:0]          s_tuser,
	input  logic                init_done,
	input  logic                q_full,
	output logic                q_push,
	output bph_pkg::job_t       q_job,
	output logic [ADDR_W-1:0]   q_addr
);

	localparam int SYM_W = $clog2(SYMBOLS);
	localparam int BCW = BYTE_COUNTER_WIDTH;

	logic [SYM_W-1:0] sym_lut [256];
	logic [BCW-1:0]   cnt_q;
	logic [BCW-1:0]   cnt_inc;
	logic [SYM_W-1:0] prev_q;
	logic [SYM_W-1:0] cur_sym;
	logic [SYM_W-1:0] row_sym;
	logic [SYM_W-1:0] col_sym;

	for (genvar i = 0; i < 256; i++) begin : g_lut
		assign sym_lut[i] = SYM_W'(i % SYMBOLS);
	end

	assign cur_sym = sym_lut[s_tdata[7:0]];
	assign row_sym = sym_lut[s_tdata[15:8]];
	assign col_sym = sym_lut[s_tdata[23:16]];
	assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;

	assign s_tready = init_done && !q_full;
	assign q_push = s_tvalid && s_tready;

	always_comb begin
		q_job.kind = bph_pkg::KIND_BAD;
		q_job.seen = bph_pkg::SEEN_W'(cnt_q);
		q_addr = '0;
		case (s_tuser)
			bph_pkg::CMD_FEED: begin
				q_job.kind = (cnt_q != '0) ? bph_pkg::KIND_FEED : bph_pkg::KIND_FIRST;
				q_job.seen = bph_pkg::SEEN_W'(cnt_inc);
				q_addr = ADDR_W'(prev_q) * ADDR_W'(SYMBOLS) + ADDR_W'(cur_sym);
			end
			bph_pkg::CMD_READ: begin
				q_job.kind = bph_pkg::KIND_READ;
				q_addr = ADDR_W'(row_sym) * ADDR_W'(SYMBOLS) + ADDR_W'(col_sym);
			end
			bph_pkg::CMD_CLEAR: begin
				q_job.kind = bph_pkg::KIND_CLEAR;
				q_job.seen = '0;
			end
			default: begin
				q_job.kind = bph_pkg::KIND_BAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			prev_q <= '0;
		end else if (q_push) begin
			case (s_tuser)
				bph_pkg::CMD_FEED: begin
					cnt_q <= cnt_inc;
					prev_q <= cur_sym;
				end
				bph_pkg::CMD_CLEAR: begin
					cnt_q <= '0;
					prev_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: design/bph_queue.sv
// Short register FIFO that decouples the front end from the back end.
// Generic in width and depth; no package dependency.
module bph_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] head
);

	localparam int PTR_W = $clog2(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   fill_q;

	assign full = (fill_q == (PTR_W+1)'(DEPTH));
	assign not_empty = (fill_q != '0);
	assign head = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// File: design/bph_back.sv
// Back end: runs table jobs (update, read, clear sweep), forms the pixel
// and holds the result register. Depends on bph_pkg and bph_ram.
module bph_back #(
	parameter int COUNT_WIDTH = bph_pkg::COUNT_WIDTH_DEF,
	parameter int SYMBOLS = bph_pkg::SYMBOLS_DEF,
	localparam int ADDR_W = $clog2(SYMBOLS * SYMBOLS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bph_pkg::GAIN_W-1:0]  gain,
	input  logic                        q_valid,
	input  bph_pkg::job_t               q_job,
	input  logic [ADDR_W-1:0]           q_addr,
	output logic                        q_pop,
	output logic                        init_done,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [103:0]                m_tdata
);

	localparam int DEPTH = SYMBOLS * SYMBOLS;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_OUT
	} state_t;

	state_t                         state_q;
	logic [ADDR_W-1:0]              clr_addr_q;
	logic                           clr_reply_q;
	logic                           init_done_q;
	bph_pkg::kind_t                 kind_q;
	logic [ADDR_W-1:0]              addr_q;
	logic [bph_pkg::SEEN_W-1:0]     seen_q;
	logic [COUNT_WIDTH-1:0]         count_q;
	logic [bph_pkg::PIXEL_W-1:0]    prod_q;
	logic                           out_valid_q;
	logic [31:0]                    out_count_q;
	logic [bph_pkg::PIXEL_W-1:0]    out_pixel_q;
	logic [bph_pkg::SEEN_W-1:0]     out_seen_q;

	logic                           ram_we;
	logic [ADDR_W-1:0]              ram_waddr;
	logic [COUNT_WIDTH-1:0]         ram_wdata;
	logic                           ram_re;
	logic [COUNT_WIDTH-1:0]         ram_rdata;
	logic [COUNT_WIDTH-1:0]         cell_inc;
	logic [31:0]                    cnt_lo;
	logic [47:0]                    mul_full;
	logic [bph_pkg::PIXEL_W-1:0]    grey;
	logic                           out_load;

	bph_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(q_addr),
		.rdata(ram_rdata)
	);

	assign cell_inc = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
	assign ram_we = (state_q == ST_CLEAR) ||
		(state_q == ST_READ && kind_q == bph_pkg::KIND_FEED);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_addr_q : addr_q;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : cell_inc;
	assign ram_re = (state_q == ST_IDLE) && q_valid;
	assign q_pop = ram_re;

	assign cnt_lo = 32'(count_q);
	assign mul_full = cnt_lo * gain;
	assign grey = bph_pkg::ALPHA_FULL | prod_q | (prod_q << 8) | (prod_q << 16);

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_tready);

	assign init_done = init_done_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata = {out_seen_q, out_pixel_q, out_count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_addr_q <= '0;
			clr_reply_q <= 1'b0;
			init_done_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (clr_addr_q == LAST_ADDR) begin
						clr_addr_q <= '0;
						init_done_q <= 1'b1;
						if (clr_reply_q) begin
							count_q <= '0;
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						clr_addr_q <= clr_addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						kind_q <= q_job.kind;
						seen_q <= q_job.seen;
						addr_q <= q_addr;
						case (q_job.kind)
							bph_pkg::KIND_CLEAR: begin
								clr_reply_q <= 1'b1;
								clr_addr_q <= '0;
								state_q <= ST_CLEAR;
							end
							bph_pkg::KIND_FEED, bph_pkg::KIND_READ: begin
								state_q <= ST_READ;
							end
							default: begin
								count_q <= '0;
								state_q <= ST_MUL;
							end
						endcase
					end
				end
				ST_READ: begin
					count_q <= (kind_q == bph_pkg::KIND_FEED) ? cell_inc : ram_rdata;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q <= mul_full[31:0];
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						out_count_q <= cnt_lo;
						out_pixel_q <= (kind_q == bph_pkg::KIND_BAD) ? '0 : grey;
						out_seen_q <= seen_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_init_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!init_done_q |-> state_q == ST_CLEAR)
		else $error("back end left clear sweep before init done");

	a_inc_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ && kind_q == bph_pkg::KIND_FEED) |-> ram_wdata != '0)
		else $error("updated cell written as zero");

	a_init_full_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(init_done_q && !$past(init_done_q)) |-> $past(clr_addr_q) == LAST_ADDR)
		else $error("init done before sweep reached last entry");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_pixel_q[31:24] != 8'hFF) |-> out_count_q == '0)
		else $error("invalid-command marker with nonzero count");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q != ST_IDLE)
		else $error("job popped without leaving idle");

endmodule

// File: design/byte_pair_histogram.sv
// Byte pair histogram top level: gain register, front end, job queue, back end.
// Depends on bph_pkg, bph_front, bph_queue, bph_back.
//
// Usage: items enter on s_tvalid/s_tready. s_tuser carries the command
// (feed byte, read cell, clear); s_tdata carries the byte and the read row and
// column. Every item gives one result on m_tvalid/m_tready: cell count, grey
// ARGB pixel (zero for an unused command) and bytes seen since the last clear.
// The back end handles one job at a time: a feed or read passes through queue
// pop with table read, update, multiply and output register, and the back end
// takes no new job until the last one has reached the output register. A first
// byte or an unused command skips the table read and update. Up to 4 items
// wait in the queue, so the input keeps taking items while results stall.
// A clear sweeps all SYMBOLS*SYMBOLS table entries (65536 by default), one
// entry per cycle, before its result appears.
// After reset the same sweep runs and s_tready stays low until it ends;
// gain writes on cfg_valid/cfg_ready are taken at any time, reset gain 1000.
// When m_tready is low the result holds and jobs back up into the queue,
// then s_tready drops.
module byte_pair_histogram #(
	parameter int COUNT_WIDTH = bph_pkg::COUNT_WIDTH_DEF,
	parameter int SYMBOLS = bph_pkg::SYMBOLS_DEF,
	parameter int BYTE_COUNTER_WIDTH = bph_pkg::BYTE_COUNTER_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [23:0]  s_tdata,  // data_byte, first_of_pair, second_of_pair
	input  logic [1:0]   s_tuser,  // command
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,  // pair_count, pixel_word, bytes_seen
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data  // pixel_gain
);

	localparam int ADDR_W = $clog2(SYMBOLS * SYMBOLS);
	localparam int QW = $bits(bph_pkg::job_t) + ADDR_W;

	logic [bph_pkg::GAIN_W-1:0] gain_q;
	logic                       init_done;
	logic                       q_full;
	logic                       q_push;
	bph_pkg::job_t              f_job;
	logic [ADDR_W-1:0]          f_addr;
	logic                       q_pop;
	logic                       q_valid;
	logic [QW-1:0]              q_head;
	bph_pkg::job_t              b_job;
	logic [ADDR_W-1:0]          b_addr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= bph_pkg::GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			gain_q <= cfg_data;
		end
	end

	bph_front #(
		.SYMBOLS(SYMBOLS),
		.BYTE_COUNTER_WIDTH(BYTE_COUNTER_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.init_done(init_done),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (f_job),
		.q_addr   (f_addr)
	);

	bph_queue #(
		.WIDTH(QW),
		.DEPTH(bph_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data({f_job, f_addr}),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_valid),
		.head     (q_head)
	);

	assign b_job = q_head[QW-1:ADDR_W];
	assign b_addr = q_head[ADDR_W-1:0];

	bph_back #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.SYMBOLS(SYMBOLS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.gain     (gain_q),
		.q_valid  (q_valid),
		.q_job    (b_job),
		.q_addr   (b_addr),
		.q_pop    (q_pop),
		.init_done(init_done),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// File: sim/byte_pair_histogram_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for byte_pair_histogram: directed and random byte streams,
// cell reads, clears and gain writes, checked against a built-in histogram predictor.
// Depends on bph_pkg and byte_pair_histogram.
module byte_pair_histogram_tb;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int SYMBOLS = bph_pkg::SYMBOLS_DEF;
	localparam int MAX_SHOWN = 10;
	localparam int IDLE_PCT = 37;
	localparam int RECENT_PAIRS = 64;

	typedef struct packed {
		logic [bph_pkg::SEEN_W-1:0] seen;
		logic [bph_pkg::PIXEL_W-1:0] pixel;
		logic [31:0] count;
	} hist_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;  // data_byte, first_of_pair, second_of_pair
	logic [1:0] s_tuser = bph_pkg::CMD_FEED;  // command
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [103:0] m_tdata;  // pair_count, pixel_word, bytes_seen
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;  // pixel_gain

	logic [bph_pkg::COUNT_WIDTH_DEF-1:0] pair_tally [int];
	logic [7:0] last_sym = '0;
	logic [bph_pkg::BYTE_COUNTER_WIDTH_DEF-1:0] byte_total = '0;
	logic [bph_pkg::GAIN_W-1:0] gain_now = bph_pkg::GAIN_RESET;

	hist_result_t expected_results [$];
	logic [15:0] fed_pairs [$];
	int mismatches = 0;
	int clears_left = 4;
	bit steady = 1'b0;

	always #2 clk = ~clk;

	byte_pair_histogram u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	function automatic logic [bph_pkg::PIXEL_W-1:0] grey_of(
		logic [bph_pkg::COUNT_WIDTH_DEF-1:0] n);
		logic [bph_pkg::PIXEL_W-1:0] p;
		p = bph_pkg::PIXEL_W'(n * gain_now);
		return bph_pkg::ALPHA_FULL | p | (p << 8) | (p << 16);
	endfunction

	function automatic hist_result_t tally_item(logic [1:0] cmd, logic [23:0] fields);
		hist_result_t r;
		logic [7:0] cur, row, col;
		int slot;
		bit later;
		cur = fields[7:0] % SYMBOLS;
		row = fields[15:8] % SYMBOLS;
		col = fields[23:16] % SYMBOLS;
		r.count = '0;
		r.pixel = bph_pkg::ALPHA_FULL;
		case (cmd)
			bph_pkg::CMD_FEED: begin
				later = (byte_total != 0);
				if (byte_total != '1)
					byte_total++;
				if (later) begin
					slot = last_sym * SYMBOLS + cur;
					if (!pair_tally.exists(slot))
						pair_tally[slot] = '0;
					if (pair_tally[slot] != '1)
						pair_tally[slot]++;
					r.count = pair_tally[slot];
					fed_pairs.push_back({last_sym, cur});
					if (fed_pairs.size() > RECENT_PAIRS)
						void'(fed_pairs.pop_front());
				end
				last_sym = cur;
				r.pixel = grey_of(r.count);
			end
			bph_pkg::CMD_READ: begin
				slot = row * SYMBOLS + col;
				if (pair_tally.exists(slot))
					r.count = pair_tally[slot];
				r.pixel = grey_of(r.count);
			end
			bph_pkg::CMD_CLEAR: begin
				pair_tally.delete();
				fed_pairs.delete();
				byte_total = '0;
				last_sym = '0;
			end
			default: begin
				r.pixel = '0;
			end
		endcase
		r.seen = byte_total;
		return r;
	endfunction

	task automatic check_field(string name, logic [bph_pkg::SEEN_W-1:0] want,
		logic [bph_pkg::SEEN_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= MAX_SHOWN)
				$display("%s mismatch: expected %h, got %h", name, want, got);
		end
	endtask

	always @(posedge clk) begin
		hist_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("result with none expected: %h", m_tdata);
			end else begin
				want = expected_results.pop_front();
				check_field("pair_count", want.count, got.count);
				check_field("pixel_word", want.pixel, got.pixel);
				check_field("bytes_seen", want.seen, got.seen);
			end
		end
		m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	task automatic send_item(logic [1:0] cmd, logic [7:0] b, logic [7:0] row, logic [7:0] col);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {col, row, b};
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(tally_item(cmd, {col, row, b}));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_gain(logic [bph_pkg::GAIN_W-1:0] g);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= g;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		gain_now = g;
	endtask

	task automatic test_pair_counting();
		send_item(bph_pkg::CMD_FEED, 8'h00, 8'hFF, 8'hFF);
		send_item(bph_pkg::CMD_FEED, 8'hFF, 8'h00, 8'h00);
		send_item(bph_pkg::CMD_FEED, 8'hFF, 8'hFF, 8'h00);
		send_item(bph_pkg::CMD_FEED, 8'hFF, 8'h00, 8'hFF);
		send_item(bph_pkg::CMD_FEED, 8'h00, 8'hFF, 8'hFF);
		send_item(bph_pkg::CMD_FEED, 8'h00, 8'h00, 8'h00);
		send_item(bph_pkg::CMD_READ, 8'hFF, 8'hFF, 8'hFF);
		send_item(bph_pkg::CMD_READ, 8'h00, 8'h00, 8'hFF);
		send_item(bph_pkg::CMD_READ, 8'h00, 8'hA5, 8'h5A);
		send_item(bph_pkg::CMD_READ, 8'hFF, 8'hFF, 8'h00);
	endtask

	task automatic test_unused_command();
		send_item(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF);
		send_item(CMD_UNUSED, 8'h00, 8'h00, 8'h00);
	endtask

	task automatic test_gain_extremes();
		write_gain(16'hFFFF);
		send_item(bph_pkg::CMD_READ, 8'h00, 8'hFF, 8'hFF);
		send_item(bph_pkg::CMD_FEED, 8'hFF, 8'h00, 8'h00);
		write_gain(16'h0000);
		send_item(bph_pkg::CMD_READ, 8'h00, 8'hFF, 8'hFF);
		send_item(bph_pkg::CMD_FEED, 8'h00, 8'h00, 8'h00);
	endtask

	task automatic test_clear();
		send_item(bph_pkg::CMD_CLEAR, 8'hFF, 8'hFF, 8'hFF);
		send_item(bph_pkg::CMD_READ, 8'h00, 8'hFF, 8'hFF);
		send_item(bph_pkg::CMD_FEED, 8'h5A, 8'h00, 8'h00);
		send_item(bph_pkg::CMD_FEED, 8'hA5, 8'h00, 8'h00);
		send_item(bph_pkg::CMD_READ, 8'h00, 8'h5A, 8'hA5);
	endtask

	task automatic test_random_stream(int n_items);
		logic [7:0] alphabet [4];
		logic [7:0] b, row, col;
		logic [15:0] pick;
		logic [1:0] cmd;
		int roll;
		foreach (alphabet[i])
			alphabet[i] = 8'($urandom_range(255));
		repeat (n_items) begin
			roll = $urandom_range(999);
			b = ($urandom_range(9) < 7) ? alphabet[$urandom_range(3)] : 8'($urandom_range(255));
			row = 8'($urandom_range(255));
			col = 8'($urandom_range(255));
			if (roll < 3 && clears_left > 0) begin
				cmd = bph_pkg::CMD_CLEAR;
				clears_left--;
			end else if (roll < 30) begin
				cmd = CMD_UNUSED;
			end else if (roll < 330) begin
				cmd = bph_pkg::CMD_READ;
				if (fed_pairs.size() != 0 && $urandom_range(9) < 7) begin
					pick = fed_pairs[$urandom_range(fed_pairs.size() - 1)];
					row = pick[15:8];
					col = pick[7:0];
				end
			end else begin
				cmd = bph_pkg::CMD_FEED;
			end
			send_item(cmd, b, row, col);
		end
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_pair_counting();
		test_unused_command();
		test_gain_extremes();
		test_clear();
		write_gain(bph_pkg::GAIN_RESET);
		test_random_stream(400);
		steady = 1'b1;
		write_gain(16'hFFFF);
		test_random_stream(300);
		steady = 1'b0;
		write_gain(16'($urandom_range(65535)));
		test_random_stream(400);
		write_gain(16'd1);
		test_random_stream(300);
		write_gain(16'd0);
		test_random_stream(300);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("byte_pair_histogram_tb passed");
		end else begin
			$display("byte_pair_histogram_tb failed");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("byte_pair_histogram_tb failed");
		$finish;
	end

endmodule
